// File: hdl/obdt_pkg.sv
package obdt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] OP_UPDATE = 3'd0;
  localparam logic [2:0] OP_FILL_PRICE = 3'd1;
  localparam logic [2:0] OP_QTY_TO_PRICE = 3'd2;
  localparam logic [2:0] OP_AT_RANK = 3'd3;
  localparam logic [2:0] OP_RANK_FOR_PRICE = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FINAL = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [30:0] price;
    logic [31:0] volume;
    logic [31:0] sort_key;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// File: hdl/obdt_ram.sv
module obdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/order_book_depth_table_unit.sv
// Depth table of up to ENTRIES entries over two sides, stored in one slot memory with a
// single read port. An update, a quantity-to-price query and a rank-for-price query
// each take one pass over the memory. The worst-price and entry-at-rank queries test
// every entry of the asked side as a candidate with a further pass each; the
// entry-at-rank query stops at the candidate it finds. Clear, unused opcodes and
// queries on a book that is not final go straight to the result without a pass. A new
// transfer may be accepted while a result still waits at the output.
module order_book_depth_table_unit
  import obdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [15:0] entry_id,
  input  logic [2:0]  present_mask,
  input  logic [31:0] volume,
  input  logic [30:0] price,
  input  logic        side_sell,
  input  logic [31:0] sort_key,
  input  logic        deleted,
  input  logic        final_flag,
  input  logic [12:0] rank,
  input  logic        sort_key_present,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [30:0] out_price,
  output logic [31:0] out_volume,
  output logic [12:0] out_rank,
  output logic [15:0] out_entry_id
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CAND   = 5'b00010,
    S_CLATCH = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;

  logic [2:0]  q_op;
  logic [15:0] q_id;
  logic [2:0]  q_mask;
  logic [31:0] q_vol;
  logic [30:0] q_price;
  logic        q_sell;
  logic [31:0] q_key;
  logic        q_del;
  logic        q_fin;
  logic [12:0] q_rank;
  logic        q_skp;

  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] side;
  logic               book_final;

  logic [CNT_W-1:0] c;
  logic [CNT_W-1:0] j;
  logic [IDX_W-1:0] jd;
  logic             pend;
  slot_t            cand;

  logic [31:0]      acc;
  logic [CNT_W-1:0] cnt;
  logic             flag;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  slot_t            hit_data;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             best_found;
  logic [30:0]      best;

  logic [1:0]  res_status;
  logic [30:0] res_price;
  logic [31:0] res_volume;
  logic [12:0] res_rank;
  logic [15:0] res_id;

  logic [SLOT_W-1:0] rd_data;
  slot_t             rd;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_t             wr_data;

  logic        j_live;
  logic [32:0] sum33;
  logic [31:0] sum_sat;
  logic        j_better_lim;
  logic        j_at_or_better_c;
  logic        j_before_c;
  logic        scan_end;
  logic        cand_better;
  logic [12:0] rank_m1;

  obdt_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(ENTRIES)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign rd = slot_t'(rd_data);
  assign rd_addr = (state == S_CAND) ? c[IDX_W-1:0] : j[IDX_W-1:0];
  assign scan_end = (state == S_SCAN) && !pend && (j == CNT_W'(ENTRIES));
  assign rank_m1 = (q_rank == 13'd0) ? 13'd0 : q_rank - 13'd1;

  always_comb begin
    j_live = valid[jd] && (side[jd] == q_sell);
    sum33 = {1'b0, acc} + {1'b0, rd.volume};
    sum_sat = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
    j_better_lim = q_sell ? (rd.price < q_price) : (rd.price > q_price);
    j_at_or_better_c = q_sell ? (rd.price <= cand.price) : (rd.price >= cand.price);
    if (rd.price != cand.price) begin
      j_before_c = q_sell ? (rd.price < cand.price) : (rd.price > cand.price);
    end else if (rd.sort_key != cand.sort_key) begin
      j_before_c = rd.sort_key < cand.sort_key;
    end else begin
      j_before_c = rd.id < cand.id;
    end
    cand_better = q_sell ? (cand.price < best) : (cand.price > best);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = hit_idx;
    wr_data = hit_data;
    if (scan_end && (q_op == OP_UPDATE)) begin
      if (hit_found) begin
        wr_en = 1'b1;
        if (q_mask[0]) wr_data.volume = q_vol;
        if (q_mask[1]) wr_data.price = q_price;
        if (q_skp) wr_data.sort_key = q_key;
      end else if (!q_del && free_found) begin
        wr_en = 1'b1;
        wr_addr = free_idx;
        wr_data.id = q_id;
        wr_data.volume = q_mask[0] ? q_vol : 32'd0;
        wr_data.price = q_mask[1] ? q_price : 31'd0;
        wr_data.sort_key = q_skp ? q_key : 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      side <= '0;
      book_final <= 1'b0;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            q_op <= opcode;
            q_id <= entry_id;
            q_mask <= present_mask;
            q_vol <= volume;
            q_price <= price;
            q_sell <= side_sell;
            q_key <= sort_key;
            q_del <= deleted;
            q_fin <= final_flag;
            q_rank <= rank;
            q_skp <= sort_key_present;
            res_status <= ST_OK;
            res_price <= '0;
            res_volume <= '0;
            res_rank <= '0;
            res_id <= '0;
            j <= '0;
            c <= '0;
            pend <= 1'b0;
            acc <= '0;
            cnt <= '0;
            flag <= 1'b0;
            hit_found <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            case (opcode)
              OP_UPDATE: state <= S_SCAN;
              OP_CLEAR: begin
                valid <= '0;
                state <= S_DONE;
              end
              OP_FILL_PRICE, OP_AT_RANK: begin
                if (!book_final) begin
                  res_status <= ST_NOT_FINAL;
                  state <= S_DONE;
                end else begin
                  state <= S_CAND;
                end
              end
              OP_QTY_TO_PRICE, OP_RANK_FOR_PRICE: begin
                if (!book_final) begin
                  res_status <= ST_NOT_FINAL;
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CAND: begin
          if (c == CNT_W'(ENTRIES)) begin
            if (q_op == OP_FILL_PRICE && best_found) begin
              res_price <= best;
            end else begin
              res_status <= ST_ABSENT;
            end
            state <= S_DONE;
          end else if (valid[c[IDX_W-1:0]] && (side[c[IDX_W-1:0]] == q_sell)) begin
            state <= S_CLATCH;
          end else begin
            c <= c + 1'b1;
          end
        end
        S_CLATCH: begin
          cand <= rd;
          j <= '0;
          pend <= 1'b0;
          acc <= '0;
          cnt <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (pend) begin
            case (q_op)
              OP_UPDATE: begin
                if (valid[jd]) begin
                  if (!hit_found && (rd.id == q_id)) begin
                    hit_found <= 1'b1;
                    hit_idx <= jd;
                    hit_data <= rd;
                  end
                end else if (!free_found) begin
                  free_found <= 1'b1;
                  free_idx <= jd;
                end
              end
              OP_QTY_TO_PRICE: begin
                if (j_live) begin
                  acc <= sum_sat;
                  if (j_better_lim) flag <= 1'b1;
                end
              end
              OP_RANK_FOR_PRICE: begin
                if (j_live && j_better_lim) cnt <= cnt + 1'b1;
              end
              OP_FILL_PRICE: begin
                if (j_live && j_at_or_better_c) acc <= sum_sat;
              end
              OP_AT_RANK: begin
                if (j_live && j_before_c) cnt <= cnt + 1'b1;
              end
              default: ;
            endcase
          end
          if (j != CNT_W'(ENTRIES)) begin
            jd <= j[IDX_W-1:0];
            j <= j + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (scan_end) begin
            case (q_op)
              OP_UPDATE: begin
                book_final <= q_fin;
                if (hit_found) begin
                  if (q_mask[2]) side[hit_idx] <= q_sell;
                  if (q_del) valid[hit_idx] <= 1'b0;
                end else if (!q_del) begin
                  if (free_found) begin
                    valid[free_idx] <= 1'b1;
                    side[free_idx] <= q_mask[2] ? q_sell : 1'b1;
                  end else begin
                    res_status <= ST_FULL;
                  end
                end
                state <= S_DONE;
              end
              OP_QTY_TO_PRICE: begin
                res_volume <= flag ? 32'd0 : acc;
                state <= S_DONE;
              end
              OP_RANK_FOR_PRICE: begin
                res_rank <= 13'(cnt) + 13'd1;
                state <= S_DONE;
              end
              OP_FILL_PRICE: begin
                if (acc >= q_vol && (!best_found || cand_better)) begin
                  best_found <= 1'b1;
                  best <= cand.price;
                end
                c <= c + 1'b1;
                state <= S_CAND;
              end
              default: begin
                if (13'(cnt) == rank_m1) begin
                  res_price <= cand.price;
                  res_volume <= cand.volume;
                  res_id <= cand.id;
                  state <= S_DONE;
                end else begin
                  c <= c + 1'b1;
                  state <= S_CAND;
                end
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            out_price <= res_price;
            out_volume <= res_volume;
            out_rank <= res_rank;
            out_entry_id <= res_id;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
